FILE: hw/rtl/fnv_linear_probe_hash_map_macros.svh
// Assertion macros for the hash map RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FNV_LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define FNV_LINEAR_PROBE_HASH_MAP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FNVLP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fnvlp assertion failed");
`define FNVLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fnvlp implication failed");
`else
`define FNVLP_ASSERT(lbl, clk, rst_n, prop)
`define FNVLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/fnvlp_pkg.sv
// Shared types, constants and helpers for the FNV linear probe hash map.
// No dependencies.
package fnvlp_pkg;

  typedef enum logic [1:0] {
    CMD_GET = 2'd0,
    CMD_PUT = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  function automatic logic [63:0] canon_key(input logic [63:0] key, input int unsigned nbytes);
    logic [63:0] r;
    logic        live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (key[8*i +: 8] == 8'd0 || i >= nbytes) live = 1'b0;
      if (live) r[8*i +: 8] = key[8*i +: 8];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/fnvlp_if.sv
// Request and response channel interfaces of the hash map.
// No dependencies.
interface fnvlp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] key;
  logic [31:0] value;
  modport source (output valid, cmd, key, value, input ready);
  modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface fnvlp_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] value_out;
  logic        full_res;
  modport source (output valid, found, value_out, full_res, input ready);
  modport sink   (input valid, found, value_out, full_res, output ready);
endinterface

FILE: hw/rtl/fnvlp_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module fnvlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hw/rtl/fnvlp_front.sv
// Front end: accepts request words, canonicalizes the key, hashes it and
// reduces the hash to a home slot. Depends on fnvlp_pkg and fnvlp_if.
module fnvlp_front #(
  parameter int TABLE_SIZE = 64,
  parameter int KEY_BYTES  = 8,
  parameter int IW         = $clog2(TABLE_SIZE),
  parameter int EW         = 98 + IW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fnvlp_req_if.sink     req_i,
  output logic          push_o,
  output logic [EW-1:0] ent_o,
  input  logic          full_i
);
  localparam int TW = IW + 5;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} fstate_e;

  fstate_e     state_q;
  logic [1:0]  cmd_q;
  logic [63:0] ck_q;
  logic [63:0] sh_q;
  logic [31:0] val_q;
  logic [31:0] h_q;
  logic [TW-1:0] r_q;
  logic [TW-1:0] r_d;
  logic [2:0]  dcnt_q;
  logic [31:0] mul;
  logic [63:0] ck_in;

  assign mul   = h_q * fnvlp_pkg::FNV_PRIME;
  assign ck_in = fnvlp_pkg::canon_key(req_i.key, KEY_BYTES);

  always_comb begin
    r_d = TW'({r_q[IW-1:0], h_q[31:28]});
    for (int k = 3; k >= 0; k--) begin
      if (r_d >= (TW'(TABLE_SIZE) << k)) r_d = r_d - (TW'(TABLE_SIZE) << k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (req_i.valid) begin
            cmd_q   <= req_i.cmd;
            ck_q    <= ck_in;
            sh_q    <= ck_in;
            val_q   <= req_i.value;
            h_q     <= fnvlp_pkg::FNV_BASIS;
            state_q <= F_HASH;
          end
        end
        F_HASH: begin
          if (sh_q[7:0] == 8'd0) begin
            r_q     <= '0;
            dcnt_q  <= '0;
            state_q <= F_MOD;
          end else begin
            h_q  <= mul ^ {24'd0, sh_q[7:0]};
            sh_q <= sh_q >> 8;
          end
        end
        F_MOD: begin
          r_q    <= r_d;
          h_q    <= {h_q[27:0], 4'd0};
          dcnt_q <= dcnt_q + 3'd1;
          if (dcnt_q == 3'd7) state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign req_i.ready = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign ent_o       = {cmd_q, ck_q, val_q, r_q[IW-1:0]};
endmodule

FILE: hw/rtl/fnvlp_fifo.sv
// Two-entry queue between the front end and the table engine.
// No dependencies.
module fnvlp_fifo #(
  parameter int W = 104
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q;
  logic         rp_q;
  logic [1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        mem_q[wp_q] <= data_i;
        wp_q        <= ~wp_q;
      end
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];
endmodule

FILE: hw/rtl/fnvlp_back.sv
// Table engine: probes slots, applies get, put and delete, repacks the
// table after a delete that hits and registers the response word.
// Depends on fnvlp_pkg, fnvlp_if, fnvlp_ram and the assertion macros.
`include "fnv_linear_probe_hash_map_macros.svh"
module fnvlp_back #(
  parameter int TABLE_SIZE  = 64,
  parameter int SPARE_SLOTS = 5,
  parameter int IW          = $clog2(TABLE_SIZE),
  parameter int EW          = 98 + IW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [EW-1:0] ent_i,
  output logic          pop_o,
  fnvlp_rsp_if.source   rsp_o
);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int XW = CW + 5;
  localparam int RW = 96 + IW;

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_CMP, S_RES, S_RA_RD, S_RA_WR, S_RB_START, S_RB_RD,
    S_RB_WAIT, S_RB_PROBE
  } bstate_e;

  bstate_e            state_q;
  fnvlp_pkg::cmd_e    cmd_q;
  logic [63:0]        ck_q;
  logic [31:0]        val_q;
  logic [IW-1:0]      home_q;
  logic [IW-1:0]      idx_q;
  logic [IW-1:0]      i_q;
  logic [CW-1:0]      n_q;
  logic [CW-1:0]      j_q;
  logic [CW-1:0]      cnt_q;
  logic [TABLE_SIZE-1:0] valid_q;
  logic               rep_q;
  logic               res_found_q, res_full_q;
  logic [31:0]        res_val_q;
  logic               ovld_q, ofound_q, ofull_q;
  logic [31:0]        oval_q;

  fnvlp_pkg::cmd_e e_cmd;
  logic [63:0]   e_key;
  logic [31:0]   e_val;
  logic [IW-1:0] e_home;

  logic          s_we, s_re, t_we, t_re;
  logic [IW-1:0] s_wa, s_ra, t_wa, t_ra;
  logic [RW-1:0] s_wd, s_rd, t_rd;
  logic [63:0]   s_key;
  logic [31:0]   s_val;
  logic [IW-1:0] s_home, t_home;
  logic          room;
  logic [IW-1:0] idx_nx;
  logic          res_load;

  assign e_cmd  = fnvlp_pkg::cmd_e'(ent_i[EW-1 -: 2]);
  assign e_key  = ent_i[IW+95 -: 64];
  assign e_val  = ent_i[IW+31 -: 32];
  assign e_home = ent_i[IW-1:0];

  assign s_key  = s_rd[RW-1 -: 64];
  assign s_val  = s_rd[IW+31 -: 32];
  assign s_home = s_rd[IW-1:0];
  assign t_home = t_rd[IW-1:0];

  assign room     = (XW'(cnt_q) + XW'(SPARE_SLOTS)) < XW'(TABLE_SIZE);
  assign idx_nx   = (idx_q == IW'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
  assign pop_o    = (state_q == S_IDLE) && valid_i;
  assign res_load = (state_q == S_RES) && (!ovld_q || rsp_o.ready);

  always_comb begin
    s_we = 1'b0;
    s_wa = idx_q;
    s_wd = {ck_q, val_q, home_q};
    s_re = 1'b0;
    s_ra = idx_q;
    t_we = 1'b0;
    t_wa = n_q[IW-1:0];
    t_re = 1'b0;
    t_ra = j_q[IW-1:0];
    case (state_q)
      S_ISSUE: begin
        if (!valid_q[idx_q]) begin
          s_we = (cmd_q == fnvlp_pkg::CMD_PUT) && room;
        end else begin
          s_re = 1'b1;
        end
      end
      S_CMP: begin
        s_we = (s_key == ck_q) && (cmd_q == fnvlp_pkg::CMD_PUT);
        s_wd = {ck_q, val_q, s_home};
      end
      S_RA_RD: begin
        s_re = valid_q[i_q];
        s_ra = i_q;
      end
      S_RA_WR:    t_we = 1'b1;
      S_RB_RD:    t_re = 1'b1;
      S_RB_PROBE: begin
        s_we = !valid_q[idx_q];
        s_wd = t_rd;
      end
      default: ;
    endcase
  end

  fnvlp_ram #(.WIDTH(RW), .DEPTH(TABLE_SIZE)) u_slot_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd),
    .re_i(s_re), .raddr_i(s_ra), .rdata_o(s_rd)
  );

  fnvlp_ram #(.WIDTH(RW), .DEPTH(TABLE_SIZE)) u_temp_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(s_rd),
    .re_i(t_re), .raddr_i(t_ra), .rdata_o(t_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      rep_q   <= 1'b0;
    end else begin
      if (res_load) ovld_q <= 1'b1;
      else if (rsp_o.ready) ovld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            cmd_q       <= e_cmd;
            ck_q        <= e_key;
            val_q       <= e_val;
            home_q      <= e_home;
            idx_q       <= e_home;
            n_q         <= '0;
            rep_q       <= 1'b0;
            res_found_q <= 1'b0;
            res_val_q   <= '0;
            res_full_q  <= 1'b0;
            state_q     <= (e_cmd == fnvlp_pkg::CMD_NOP) ? S_RES : S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (!valid_q[idx_q]) begin
            if (cmd_q == fnvlp_pkg::CMD_PUT) begin
              if (room) begin
                valid_q[idx_q] <= 1'b1;
                cnt_q          <= cnt_q + 1'b1;
              end else begin
                res_full_q <= 1'b1;
              end
            end
            state_q <= S_RES;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (s_key == ck_q) begin
            res_found_q <= 1'b1;
            res_val_q   <= s_val;
            if (cmd_q == fnvlp_pkg::CMD_DEL) begin
              valid_q[idx_q] <= 1'b0;
              if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
              rep_q <= 1'b1;
            end
            state_q <= S_RES;
          end else if (n_q == CW'(TABLE_SIZE - 1)) begin
            if (cmd_q == fnvlp_pkg::CMD_PUT) res_full_q <= 1'b1;
            state_q <= S_RES;
          end else begin
            idx_q   <= idx_nx;
            n_q     <= n_q + 1'b1;
            state_q <= S_ISSUE;
          end
        end
        S_RES: begin
          if (res_load) begin
            ofound_q <= res_found_q;
            oval_q   <= res_val_q;
            ofull_q  <= res_full_q;
            if (rep_q) begin
              i_q     <= '0;
              n_q     <= '0;
              state_q <= S_RA_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_RA_RD: begin
          if (valid_q[i_q]) begin
            valid_q[i_q] <= 1'b0;
            state_q      <= S_RA_WR;
          end else if (i_q == IW'(TABLE_SIZE - 1)) begin
            state_q <= S_RB_START;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_RA_WR: begin
          n_q <= n_q + 1'b1;
          if (i_q == IW'(TABLE_SIZE - 1)) begin
            state_q <= S_RB_START;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_RA_RD;
          end
        end
        S_RB_START: begin
          j_q     <= '0;
          state_q <= (n_q == '0) ? S_IDLE : S_RB_RD;
        end
        S_RB_RD:   state_q <= S_RB_WAIT;
        S_RB_WAIT: begin
          idx_q   <= t_home;
          state_q <= S_RB_PROBE;
        end
        S_RB_PROBE: begin
          if (!valid_q[idx_q]) begin
            valid_q[idx_q] <= 1'b1;
            j_q            <= j_q + 1'b1;
            state_q        <= (CW'(j_q + 1'b1) == n_q) ? S_IDLE : S_RB_RD;
          end else begin
            idx_q <= idx_nx;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid     = ovld_q;
  assign rsp_o.found     = ofound_q;
  assign rsp_o.value_out = oval_q;
  assign rsp_o.full_res  = ofull_q;

  `FNVLP_ASSERT(a_cnt_bound, clk_i, rst_ni, XW'(cnt_q) + XW'(SPARE_SLOTS) <= XW'(TABLE_SIZE))
  `FNVLP_ASSERT_IMP(a_cnt_match, clk_i, rst_ni, state_q == S_IDLE, $countones(valid_q) == int'(cnt_q))
  `FNVLP_ASSERT_IMP(a_rb_range, clk_i, rst_ni, state_q == S_RB_PROBE, j_q < n_q)
endmodule

FILE: hw/rtl/fnv_linear_probe_hash_map.sv
// Hash map top level: front end, request queue and table engine.
// Depends on fnvlp_pkg, fnvlp_if, fnvlp_front, fnvlp_fifo and fnvlp_back.
//
// Key-value store with TABLE_SIZE slots, open addressing and linear probing
// from the FNV-1 hash of the key (bytes up to the first zero, at most
// KEY_BYTES) modulo TABLE_SIZE. Every request word (get, put, delete, no-op)
// gives exactly one response word. The front end takes a word only while
// idle, hashes the key bytes, reduces the hash to a home slot four bits at
// a time and queues it; it takes no new word before that one is queued.
// The table engine runs behind a two-entry queue, reads each occupied
// probed slot through its slot RAM port until a match or an empty slot
// ends the probe, and registers the response word; a delete that hits adds
// a repack that drains the remaining entries into a scratch RAM and places
// each back by probing from its home slot. Inserts are refused with
// full_res once the entry count plus SPARE_SLOTS reaches TABLE_SIZE.
module fnv_linear_probe_hash_map #(
  parameter int TABLE_SIZE  = 64,
  parameter int KEY_BYTES   = 8,
  parameter int SPARE_SLOTS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fnvlp_req_if.sink   req_i,
  fnvlp_rsp_if.source rsp_o
);
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int EW = 98 + IW;

  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  logic [EW-1:0] ent_in;
  logic [EW-1:0] ent_out;

  fnvlp_front #(.TABLE_SIZE(TABLE_SIZE), .KEY_BYTES(KEY_BYTES), .IW(IW), .EW(EW)) u_front (
    .clk_i, .rst_ni, .req_i, .push_o(push), .ent_o(ent_in), .full_i(full)
  );

  fnvlp_fifo #(.W(EW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(ent_in), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .data_o(ent_out)
  );

  fnvlp_back #(.TABLE_SIZE(TABLE_SIZE), .SPARE_SLOTS(SPARE_SLOTS), .IW(IW), .EW(EW)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .ent_i(ent_out), .pop_o(pop), .rsp_o
  );
endmodule
